/* hdl/dsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_pkg: shared types for the deadline slot allocator
// Item layouts, controller states and fixed field widths.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int unsigned TOTAL_BITS  = 22;
  localparam int unsigned CFG_BITS    = 7;
  localparam logic [CFG_BITS-1:0] SLOTS_RESET = 7'd64;

  typedef struct packed {
    logic        start_new_set;
    logic [7:0]  job_id;
    logic [15:0] profit;
    logic [7:0]  deadline;
  } in_item_t;

  typedef struct packed {
    logic                  placed;
    logic [5:0]            slot_index;
    logic [7:0]            job_id_out;
    logic [TOTAL_BITS-1:0] running_sum;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LAUNCH,
    ST_SEARCH
  } state_t;

endpackage
`default_nettype wire

/* hdl/deadline_slot_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_slot_allocator: greedy job sequencing with deadlines
// Places each job in the latest free slot at or before its deadline.
// ----------------------------------------------------------------------------
// Flow: accept, then LAUNCH; when L = min(deadline, slot count, MAX_SLOTS) is 0,
//   LAUNCH reports a drop, else SEARCH probes down from slot L - 1, one read per cycle.
// A job with start_new_set set first sweeps the slot map. One item at a time:
//   busy drops with done, so the next item can be accepted in that same cycle.
// Reset: synchronous; clears the total and sweeps the slot map (busy high),
//   slot count returns to 64. Results cannot be stalled.
module deadline_slot_allocator #(
  parameter int unsigned MAX_SLOTS   = 64,
  parameter int unsigned PROFIT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // item input
  input  wire logic                          start,
  input  wire dsa_pkg::in_item_t             item_in,
  output logic                               busy,
  // result output, one cycle strobe
  output logic                               done,
  output dsa_pkg::out_item_t                 result,
  // slot count register
  input  wire logic                          cfg_wr_en,
  input  wire logic [dsa_pkg::CFG_BITS-1:0]  cfg_wr_data
);

  // Address width of the slot map, and a count wide enough to hold MAX_SLOTS.
  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = AW + 1;
  // Width used to compare deadline, register and MAX_SLOTS.
  localparam int unsigned LW = (CW > 8) ? CW : 8;
  localparam int unsigned TB = dsa_pkg::TOTAL_BITS;
  // Profit is taken in its low PROFIT_BITS bits.
  localparam logic [15:0] PROFIT_MASK =
    (PROFIT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << PROFIT_BITS) - 32'd1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS - 1);

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  dsa_pkg::state_t state, state_next;

  logic [dsa_pkg::CFG_BITS-1:0] slots_in_use;
  logic [TB-1:0]                total;        // running profit of this set
  logic                         resume;       // sweep was started by a job
  logic [AW-1:0]                clr_addr;     // sweep pointer
  logic [7:0]                   job_q;
  logic [15:0]                  profit_q;
  logic [CW-1:0]                limit;        // number of slots to probe
  logic [AW-1:0]                probe_addr;   // next entry to read
  logic [CW-1:0]                probe_left;   // reads still to issue
  logic                         rd_valid;     // rd_data belongs to a probe
  logic                         rd_last;      // that probe was slot 0
  logic [AW-1:0]                rd_addr_q;
  logic                         rd_data;

  // Slot occupied map: one bit per slot, one write and one read port.
  logic slot_mem [MAX_SLOTS];

  // ---------------------------------------------------------------------
  // Item decode at accept: effective limit = min(deadline, count, MAX_SLOTS)
  // ---------------------------------------------------------------------
  logic          accept;
  logic [LW-1:0] cnt_ext;
  logic [LW-1:0] cnt_eff;
  logic [LW-1:0] dl_ext;
  logic [LW-1:0] limit_w;

  assign accept  = start && !busy;
  assign cnt_ext = LW'(slots_in_use);
  assign cnt_eff = (cnt_ext > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : cnt_ext;
  assign dl_ext  = LW'(item_in.deadline);
  assign limit_w = (dl_ext < cnt_eff) ? dl_ext : cnt_eff;

  // ---------------------------------------------------------------------
  // Search decisions: a probe result is registered and arrives in the cycle after its read.
  // A free entry ends the search; an occupied slot 0 means no slot left.
  // ---------------------------------------------------------------------
  logic found;
  logic miss;
  logic issue;
  logic clear_last;

  assign found      = (state == dsa_pkg::ST_SEARCH) && rd_valid && !rd_data;
  assign miss       = (state == dsa_pkg::ST_SEARCH) && rd_valid && rd_data && rd_last;
  assign issue      = (state == dsa_pkg::ST_SEARCH) && !found && !miss &&
                      (probe_left != '0);
  assign clear_last = (clr_addr == LAST_ADDR);

  // Saturating add of the job's profit to the set total.
  logic [TB:0]   sum_w;
  logic [TB-1:0] total_sat;

  assign sum_w     = {1'b0, total} + (TB+1)'(profit_q);
  assign total_sat = sum_w[TB] ? {TB{1'b1}} : sum_w[TB-1:0];

  // slot_index carries the low six bits of the slot number.
  logic [15:0] slot_wide;
  assign slot_wide = 16'(rd_addr_q);

  // Memory write port: sweep writes zero, a placed job marks its slot.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 1'b0;
    if (state == dsa_pkg::ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (found) begin
      mem_we    = 1'b1;
      mem_waddr = rd_addr_q;
      mem_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data <= slot_mem[probe_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    unique case (state)
      dsa_pkg::ST_CLEAR: begin
        if (clear_last) begin
          state_next = resume ? dsa_pkg::ST_LAUNCH : dsa_pkg::ST_IDLE;
        end
      end
      dsa_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = item_in.start_new_set ? dsa_pkg::ST_CLEAR : dsa_pkg::ST_LAUNCH;
        end
      end
      dsa_pkg::ST_LAUNCH: begin
        state_next = (limit == '0) ? dsa_pkg::ST_IDLE : dsa_pkg::ST_SEARCH;
      end
      dsa_pkg::ST_SEARCH: begin
        if (found || miss) begin
          state_next = dsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dsa_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath and control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= dsa_pkg::SLOTS_RESET;
      total        <= '0;
      resume       <= 1'b0;
      clr_addr     <= '0;
      rd_valid     <= 1'b0;
      done         <= 1'b0;
    end else begin
      // strobe on a placement, a drop, or an empty probe range
      done <= found || miss || ((state == dsa_pkg::ST_LAUNCH) && (limit == '0));
      if (cfg_wr_en) begin
        slots_in_use <= cfg_wr_data;
      end

      if (state == dsa_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
        if (clear_last) begin
          resume <= 1'b0;
        end
      end

      if (accept) begin
        job_q    <= item_in.job_id;
        profit_q <= item_in.profit & PROFIT_MASK;
        limit    <= CW'(limit_w);
        if (item_in.start_new_set) begin
          total    <= '0;
          resume   <= 1'b1;
          clr_addr <= '0;
        end
      end

      if (state == dsa_pkg::ST_LAUNCH) begin
        probe_addr <= AW'(limit - CW'(1));
        probe_left <= limit;
        rd_valid   <= 1'b0;
        if (limit == '0) begin
          result.placed      <= 1'b0;
          result.slot_index  <= '0;
          result.job_id_out  <= job_q;
          result.running_sum <= total;
        end
      end

      if (state == dsa_pkg::ST_SEARCH) begin
        rd_valid <= issue;
        if (issue) begin
          rd_addr_q  <= probe_addr;
          rd_last    <= (probe_left == CW'(1));
          probe_addr <= probe_addr - AW'(1);
          probe_left <= probe_left - CW'(1);
        end
      end

      if (found) begin
        total              <= total_sat;
        result.placed      <= 1'b1;
        result.slot_index  <= slot_wide[5:0];
        result.job_id_out  <= job_q;
        result.running_sum <= total_sat;
      end else if (miss) begin
        result.placed      <= 1'b0;
        result.slot_index  <= '0;
        result.job_id_out  <= job_q;
        result.running_sum <= total;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/dsa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_checker: port-level checks for the deadline slot allocator
// Watches the item handshake and result strobe over time.
// ----------------------------------------------------------------------------
module dsa_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire dsa_pkg::out_item_t result
);

  // Reset starts the slot map sweep.
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // An accepted item keeps the block busy until its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after accept");

  // A result is shown only as the block goes idle, never twice in a row.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held");

  // A dropped job reports slot zero.
  a_drop_slot: assert property (@(posedge clk) disable iff (rst)
    (done && !result.placed) |-> (result.slot_index == '0))
    else $error("dropped job with slot");

endmodule

bind deadline_slot_allocator dsa_checker u_dsa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire

/* sim/dsa_result_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_result_monitor: slot placement predictor and result compare
// Follows accepted jobs and slot count writes, works out each placement,
// and compares every done strobe with the oldest placement still due.
// ----------------------------------------------------------------------------
module dsa_result_monitor #(
  parameter int unsigned MAX_SLOTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire dsa_pkg::in_item_t             item_in,
  input  wire logic                          done,
  input  wire dsa_pkg::out_item_t            result,
  input  wire logic                          cfg_wr_en,
  input  wire logic [dsa_pkg::CFG_BITS-1:0]  cfg_wr_data,
  output int                                 mismatches,
  output int                                 outstanding
);

  localparam logic [dsa_pkg::TOTAL_BITS-1:0] TOTAL_CEIL = '1;

  logic [MAX_SLOTS-1:0]           occupied;
  logic [dsa_pkg::TOTAL_BITS-1:0] set_total;
  logic [dsa_pkg::CFG_BITS-1:0]   slot_count;
  dsa_pkg::out_item_t             placements_due[$];
  int                             fail_total = 0;

  // Latest free slot at or before the clamped deadline; updates map and total.
  function automatic dsa_pkg::out_item_t place_job(input dsa_pkg::in_item_t job);
    dsa_pkg::out_item_t             r;
    int unsigned                    span;
    int unsigned                    s;
    logic [dsa_pkg::TOTAL_BITS:0]   sum;
    r = '0;
    if (job.start_new_set) begin
      occupied  = '0;
      set_total = '0;
    end
    span = (slot_count > MAX_SLOTS) ? MAX_SLOTS : slot_count;
    if (job.deadline < span) span = job.deadline;
    s = span;
    while (s > 0 && !r.placed) begin
      if (!occupied[s-1]) begin
        occupied[s-1] = 1'b1;
        r.placed      = 1'b1;
        r.slot_index  = 6'(s - 1);
      end
      s = s - 1;
    end
    if (r.placed) begin
      sum = {1'b0, set_total} + (dsa_pkg::TOTAL_BITS+1)'(job.profit);
      set_total = (sum > {1'b0, TOTAL_CEIL}) ? TOTAL_CEIL
                                             : sum[dsa_pkg::TOTAL_BITS-1:0];
    end
    r.job_id_out  = job.job_id;
    r.running_sum = set_total;
    return r;
  endfunction

  function automatic void compare_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      fail_total++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    dsa_pkg::out_item_t want;
    if (rst) begin
      occupied   = '0;
      set_total  = '0;
      slot_count = dsa_pkg::SLOTS_RESET;
      placements_due.delete();
    end else begin
      // a result leaving on this edge belongs to an earlier job
      if (done) begin
        if (placements_due.size() == 0) begin
          fail_total++;
          $display("%0t: result with no job due, expected none, got %p", $time, result);
        end else begin
          want = placements_due.pop_front();
          compare_field("placed", want.placed, result.placed);
          compare_field("slot_index", want.slot_index, result.slot_index);
          compare_field("job_id_out", want.job_id_out, result.job_id_out);
          compare_field("running_sum", want.running_sum, result.running_sum);
        end
      end
      if (cfg_wr_en) slot_count = cfg_wr_data;
      if (start && !busy) placements_due.push_back(place_job(item_in));
    end
    mismatches  <= fail_total;
    outstanding <= placements_due.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: deadline slot allocator testbench
// Directed corner jobs, then randomized job sets across several slot counts,
// with bursty job issue; the result monitor predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  // Worst item: set clear sweep + full search + issue gap.
  // ~1800 items even at that worst pace stay well under this bound.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 140;
  localparam int unsigned PHASE_JOBS  = 174;

  logic                         clk;
  logic                         rst         = 1'b1;
  logic                         start       = 1'b0;
  dsa_pkg::in_item_t            item_in     = '0;
  logic                         cfg_wr_en   = 1'b0;
  logic [dsa_pkg::CFG_BITS-1:0] cfg_wr_data = '0;
  logic                         busy;
  logic                         done;
  dsa_pkg::out_item_t           result;
  int                           mismatches;
  int                           outstanding;
  int unsigned                  cycles      = 0;
  int                           burst_left  = 4;
  int                           slots_now   = 64;

  deadline_slot_allocator dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item_in     (item_in),
    .busy        (busy),
    .done        (done),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  dsa_result_monitor mon (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item_in     (item_in),
    .done        (done),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one job at the falling edge, hold until taken (start high, busy
  // low at a rising edge). start stays high into the next job of a burst; at
  // the end of a burst the sender goes quiet for a random gap.
  task automatic send_job(input logic new_set, input logic [7:0] id,
                          input logic [15:0] gain, input logic [7:0] due);
    @(negedge clk);
    start                 = 1'b1;
    item_in.start_new_set = new_set;
    item_in.job_id        = id;
    item_in.profit        = gain;
    item_in.deadline      = due;
    do @(posedge clk); while (busy);
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      // now and then a long stretch with no idle cycles
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Hold off until every result is out and the block is idle.
  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (busy || outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Slot count writes only happen with the block drained.
  task automatic write_slots(input int value);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = dsa_pkg::CFG_BITS'(value);
    slots_now   = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // Mostly well-formed job sets: a set opener, then profits that fall, with
  // deadlines mostly near the usable slot range. The rest is noise: stray set
  // openers and fully random fields.
  task automatic run_sets(input int count);
    int sent;
    int len;
    int usable;
    int j;
    int gain;
    int step;
    int due;
    sent = 0;
    while (sent < count) begin
      usable = (slots_now > 64) ? 64 : slots_now;
      if ($urandom_range(0, 9) < 8) begin
        len  = $urandom_range(1, usable + 3);
        gain = $urandom_range(0, 65535);
        for (j = 0; j < len && sent < count; j++) begin
          due = ($urandom_range(0, 3) != 0) ? $urandom_range(0, usable + 1)
                                            : $urandom_range(0, 255);
          send_job(j == 0, 8'($urandom), 16'(gain), 8'(due));
          sent++;
          step = $urandom_range(0, gain / 8 + 64);
          gain = (gain > step) ? gain - step : 0;
        end
      end else begin
        send_job(1'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
        sent++;
      end
      // occasionally let everything drain mid-phase
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  initial begin
    int settings[10];
    int p;
    settings = '{2, 64, 65, 16, 127, 0, 1, 33, 0, 0};
    settings[8] = $urandom_range(0, 127);
    settings[9] = $urandom_range(1, 64);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // reset sweeps the slot map with busy high
    drain();

    // default 64 slots: clamp, zero profit, zero deadline, set restart
    send_job(1'b1, 8'h00, 16'hFFFF, 8'd255);   // clamps to slot 63
    send_job(1'b0, 8'hFF, 16'h0000, 8'd1);     // zero profit still holds slot 0
    send_job(1'b0, 8'h01, 16'h0000, 8'd1);     // slot 0 taken: dropped
    send_job(1'b0, 8'h02, 16'd100, 8'd0);      // deadline zero: dropped
    send_job(1'b0, 8'h03, 16'd90, 8'd64);      // 63 taken, falls to 62
    send_job(1'b0, 8'h04, 16'hAAAA, 8'h55);
    send_job(1'b0, 8'h05, 16'h5555, 8'hAA);
    send_job(1'b1, 8'h06, 16'd70, 8'd1);       // new set clears the map
    send_job(1'b0, 8'h07, 16'd60, 8'd128);

    write_slots(1);
    send_job(1'b1, 8'h08, 16'd50, 8'd255);
    send_job(1'b0, 8'h09, 16'd40, 8'd1);       // only slot taken: dropped

    write_slots(0);                            // zero slots drops everything
    send_job(1'b1, 8'h0A, 16'd30, 8'd5);
    send_job(1'b0, 8'h0B, 16'd20, 8'd0);

    write_slots(127);                          // beyond the map: limited to 64
    send_job(1'b1, 8'h0C, 16'd10, 8'd200);
    send_job(1'b0, 8'h0D, 16'hFFFF, 8'd64);
    send_job(1'b0, 8'h0E, 16'h0001, 8'd63);

    for (p = 0; p < 10; p++) begin
      write_slots(settings[p]);
      run_sets(PHASE_JOBS);
    end

    drain();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/dsa_pkg.sv
hdl/deadline_slot_allocator.sv
hdl/dsa_checker.sv
sim/dsa_result_monitor.sv
sim/tb_top.sv
